[rtl/ptrs_pkg.sv]
// Package for the periodic task release scheduler.
// Command and result codes, controller states, controller/datapath structs.
// No dependencies.
package ptrs_pkg;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_CREATE  = 3'd1,
        CMD_RESUME  = 3'd2,
        CMD_SUSPEND = 3'd3,
        CMD_DELETE  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ACCEPT   = 2'd0,
        KIND_REJECT   = 2'd1,
        KIND_DISPATCH = 2'd2,
        KIND_IDLE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_FLUSH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic walk_start;
        logic consume;
        logic issue;
        logic create_do;
        logic resume_do;
        logic suspend_do;
        logic delete_do;
        logic flush_do;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_cmd cmd;
        logic blocked;
        logic rd_done;
        logic loadable;
    } t_dp_stat;

endpackage

[rtl/ptrs_ctrl.sv]
// Controller state machine for the periodic task release scheduler.
// Sequences command execution and the slot walk; uses ptrs_pkg.
module ptrs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ptrs_pkg::t_dp_stat  i_stat,
    output ptrs_pkg::t_dp_cmd   o_cmd,
    output logic                o_stall
);

    ptrs_pkg::t_state r_state;
    ptrs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptrs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != ptrs_pkg::ST_IDLE);
        unique case (r_state)
            ptrs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ptrs_pkg::ST_EXEC;
                end
            end
            ptrs_pkg::ST_EXEC: begin
                unique case (i_stat.cmd)
                    ptrs_pkg::CMD_TICK: begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = ptrs_pkg::ST_WALK;
                    end
                    ptrs_pkg::CMD_CREATE: begin
                        if (i_stat.loadable) begin
                            o_cmd.create_do = 1'b1;
                            n_state         = ptrs_pkg::ST_IDLE;
                        end
                    end
                    ptrs_pkg::CMD_RESUME: begin
                        o_cmd.resume_do = 1'b1;
                        n_state         = ptrs_pkg::ST_IDLE;
                    end
                    ptrs_pkg::CMD_SUSPEND: begin
                        o_cmd.suspend_do = 1'b1;
                        n_state          = ptrs_pkg::ST_IDLE;
                    end
                    ptrs_pkg::CMD_DELETE: begin
                        o_cmd.delete_do = 1'b1;
                        n_state         = ptrs_pkg::ST_IDLE;
                    end
                    default: begin
                        n_state = ptrs_pkg::ST_IDLE;
                    end
                endcase
            end
            ptrs_pkg::ST_WALK: begin
                if (!i_stat.blocked) begin
                    o_cmd.consume = 1'b1;
                    if (!i_stat.rd_done) begin
                        o_cmd.issue = 1'b1;
                    end else begin
                        n_state = ptrs_pkg::ST_FLUSH;
                    end
                end
            end
            ptrs_pkg::ST_FLUSH: begin
                if (i_stat.loadable) begin
                    o_cmd.flush_do = 1'b1;
                    n_state        = ptrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptrs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/ptrs_datapath.sv]
// Datapath for the periodic task release scheduler: slot flags, period and
// countdown memory, walk pipeline, held dispatch and output register. Uses ptrs_pkg.
module ptrs_datapath #(
    parameter int SLOT_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptrs_pkg::t_dp_cmd  i_cmd,
    output ptrs_pkg::t_dp_stat o_stat,
    input  logic [2:0]         i_command,
    input  logic [2:0]         i_slot,
    input  logic [15:0]        i_period,
    input  logic [7:0]         i_first_delay,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [2:0]         o_task_index,
    output logic               o_last
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // latched transaction
    ptrs_pkg::t_cmd r_cmd;
    logic [2:0]     r_slot;
    logic [15:0]    r_period;
    logic [7:0]     r_first_delay;

    // slot flags; r_written marks memory entries holding a real countdown
    logic [SLOT_COUNT-1:0] r_used;
    logic [SLOT_COUNT-1:0] r_resumed;
    logic [SLOT_COUNT-1:0] r_written;

    // {period, countdown} per slot
    logic [31:0] r_mem [SLOT_COUNT];
    logic [31:0] r_rd_data;

    logic [CW-1:0] r_rd_ptr;
    logic [IW-1:0] r_st_idx;

    logic                     r_held_v;
    logic [IW-1:0]            r_held_idx;
    logic [ptrs_pkg::CNT_W-1:0] r_cnt;

    logic            r_o_valid;
    ptrs_pkg::t_kind r_kind;
    logic [2:0]      r_task_idx;
    logic            r_o_last;

    logic          loadable;
    logic          in_range;
    logic [IW-1:0] slot_idx;
    logic          create_ok;
    logic [15:0]   cd;
    logic [15:0]   per;
    logic          disp;
    logic          dec;
    logic          report;
    logic          push_held;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    assign loadable  = !r_o_valid || !i_stall;
    assign in_range  = (32'(r_slot) < SLOT_COUNT);
    assign slot_idx  = IW'(r_slot);
    assign create_ok = in_range && !r_used[slot_idx];

    assign cd     = r_written[r_st_idx] ? r_rd_data[15:0] : 16'd0;
    assign per    = r_rd_data[31:16];
    assign disp   = r_resumed[r_st_idx] && (cd == 16'd0) && r_used[r_st_idx];
    assign dec    = r_resumed[r_st_idx] && (cd != 16'd0);
    assign report = disp && (32'(r_cnt) < ptrs_pkg::MAX_RESULTS);
    assign push_held = i_cmd.consume && report && r_held_v;

    assign o_stat.cmd      = r_cmd;
    assign o_stat.blocked  = report && r_held_v && !loadable;
    assign o_stat.rd_done  = (r_rd_ptr == CW'(SLOT_COUNT));
    assign o_stat.loadable = loadable;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_st_idx;
        mem_wdata = {per, disp ? (per - 16'd1) : (cd - 16'd1)};
        if (i_cmd.create_do && create_ok) begin
            mem_we    = 1'b1;
            mem_waddr = slot_idx;
            mem_wdata = {r_period, 8'd0, r_first_delay};
        end else if (i_cmd.consume && (disp || dec)) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.walk_start) begin
            r_rd_data <= r_mem[0];
        end else if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_rd_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd         <= ptrs_pkg::t_cmd'(i_command);
            r_slot        <= i_slot;
            r_period      <= i_period;
            r_first_delay <= i_first_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_resumed <= '0;
            r_written <= '0;
        end else begin
            if (i_cmd.create_do && create_ok) begin
                r_used[slot_idx]    <= 1'b1;
                r_resumed[slot_idx] <= 1'b1;
                r_written[slot_idx] <= 1'b1;
            end
            if (i_cmd.resume_do && in_range) begin
                r_resumed[slot_idx] <= 1'b1;
            end
            if (i_cmd.suspend_do && in_range) begin
                r_resumed[slot_idx] <= 1'b0;
            end
            if (i_cmd.delete_do && in_range) begin
                r_used[slot_idx] <= 1'b0;
            end
        end
    end

    // walk pipeline and held dispatch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_st_idx <= '0;
            r_held_v <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.walk_start) begin
                r_rd_ptr <= CW'(1);
                r_st_idx <= '0;
                r_held_v <= 1'b0;
                r_cnt    <= '0;
            end else begin
                if (i_cmd.issue) begin
                    r_rd_ptr <= r_rd_ptr + CW'(1);
                    r_st_idx <= r_rd_ptr[IW-1:0];
                end
                if (i_cmd.consume && report) begin
                    r_held_v <= 1'b1;
                    r_cnt    <= r_cnt + ptrs_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.consume && report) begin
            r_held_idx <= r_st_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.create_do || i_cmd.flush_do || push_held) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.create_do) begin
            r_kind     <= create_ok ? ptrs_pkg::KIND_ACCEPT : ptrs_pkg::KIND_REJECT;
            r_task_idx <= r_slot;
            r_o_last   <= 1'b1;
        end else if (i_cmd.flush_do) begin
            r_kind     <= r_held_v ? ptrs_pkg::KIND_DISPATCH : ptrs_pkg::KIND_IDLE;
            r_task_idx <= r_held_v ? 3'(r_held_idx) : 3'd0;
            r_o_last   <= 1'b1;
        end else if (push_held) begin
            r_kind     <= ptrs_pkg::KIND_DISPATCH;
            r_task_idx <= 3'(r_held_idx);
            r_o_last   <= 1'b0;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_kind       = r_kind;
    assign o_task_index = r_task_idx;
    assign o_last       = r_o_last;

    a_held_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_v |-> (r_cnt != '0))
        else $error("held dispatch without count");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= ptrs_pkg::MAX_RESULTS)
        else $error("dispatch count above cap");

    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.create_do || i_cmd.flush_do) |=> (r_o_valid && r_o_last))
        else $error("final result not presented");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_held |-> loadable)
        else $error("held dispatch pushed into a full output");

endmodule

[rtl/periodic_task_release_scheduler.sv]
// Top level of the periodic task release scheduler.
// Instantiates ptrs_ctrl and ptrs_datapath; uses ptrs_pkg.
//
// Usage:
//  - Input channel (i_valid / o_stall) carries one command transaction:
//    tick, create, resume, suspend or delete, with slot, period and first
//    delay. A transaction is taken when i_valid is high and o_stall low.
//  - Output channel (o_valid / i_stall) carries result transactions: kind,
//    task index and a last flag on the final result of a command.
//  - Resume, suspend, delete and unknown codes give no result and pass
//    through the execute state before the next transaction is taken;
//    create waits there until the result register can take its result.
//  - A tick walks all SLOT_COUNT slots through the period/countdown memory
//    behind a registered read, one slot per cycle unless the walk waits
//    on a full result register.
//  - The last dispatch found is held back until the walk ends so that it
//    can carry the last flag; an idle result is given when nothing fires.
//    At most eight dispatches are reported per tick.
//  - A stall on the output holds the result register; the walk waits on
//    the next dispatch while the register stays full, and o_stall stays
//    high until the command is done.
//  - Synchronous active-low reset clears all slot flags and the controller;
//    no clearing pass is needed since memory entries are flagged on create.
module periodic_task_release_scheduler #(
    parameter int SLOT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_slot,
    input  logic [15:0] i_period,
    input  logic [7:0]  i_first_delay,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_task_index,
    output logic        o_last
);

    ptrs_pkg::t_dp_cmd  dp_cmd;
    ptrs_pkg::t_dp_stat dp_stat;

    // command sequencing
    ptrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_stall (o_stall)
    );

    // slot table, walk pipeline and result register
    ptrs_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_command     (i_command),
        .i_slot        (i_slot),
        .i_period      (i_period),
        .i_first_delay (i_first_delay),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_task_index  (o_task_index),
        .o_last        (o_last)
    );

endmodule

[tb/periodic_task_release_scheduler_tb.sv]
// Testbench for periodic_task_release_scheduler: directed and random command traffic,
// with random idling on both sides, checked against a local scheduler model.
// Depends on ptrs_pkg and the scheduler RTL only.
`timescale 1ns / 100ps

module periodic_task_release_scheduler_tb;

    localparam int SLOT_COUNT      = 8;
    localparam int RANDOM_ITEMS    = 280;
    localparam int HOLD_OFF_CYCLES = 300;  // long receiver hold-off in the pressure test
    localparam int DRAIN_CYCLES    = 32;   // longer than one tick walk, plus slack
    localparam int CYCLE_LIMIT     = 400000;

    // one expected result transaction
    typedef struct {
        ptrs_pkg::t_kind kind;
        logic [2:0]      task_index;
        logic            last;
    } t_release_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_command;
    logic [2:0]  i_slot;
    logic [15:0] i_period;
    logic [7:0]  i_first_delay;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [2:0]  o_task_index;
    logic        o_last;

    periodic_task_release_scheduler #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_slot       (i_slot),
        .i_period     (i_period),
        .i_first_delay(i_first_delay),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_task_index (o_task_index),
        .o_last       (o_last)
    );

    // Local copy of the task table
    bit          occupied_m [SLOT_COUNT];
    bit          resumed_m  [SLOT_COUNT];
    logic [15:0] period_m   [SLOT_COUNT];
    logic [15:0] countdown_m[SLOT_COUNT];

    t_release_result pending_results[$];

    int  mismatch_count   = 0;
    int  results_checked  = 0;
    int  commands_sent    = 0;
    int  ticks_sent       = 0;
    int  dispatches_seen  = 0;
    int  idle_ticks       = 0;
    int  creates_taken    = 0;
    int  creates_refused  = 0;
    int  cycle_count      = 0;
    bit  no_idle          = 1'b0;  // both sides run back to back while set
    bit  hold_off_pending = 1'b0;  // receiver does one long hold-off when set

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending_results.size());
        $display("periodic_task_release_scheduler: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // Scheduler model: updates the table for one accepted command transaction
    // and queues the results it should produce, in order.
    task automatic predict_release(input logic [2:0] cmd, input logic [2:0] slot,
                                   input logic [15:0] period,
                                   input logic [7:0] first_delay);
        t_release_result batch[$];
        t_release_result r;
        int              fired;
        fired  = 0;
        r.last = 1'b0;
        case (cmd)
            ptrs_pkg::CMD_TICK: begin
                ticks_sent++;
                // ascending walk; suspended slots are frozen
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    if (resumed_m[s]) begin
                        if (countdown_m[s] == 16'd0) begin
                            if (occupied_m[s]) begin
                                if (fired < ptrs_pkg::MAX_RESULTS) begin
                                    r.kind       = ptrs_pkg::KIND_DISPATCH;
                                    r.task_index = 3'(s);
                                    batch.push_back(r);
                                    fired++;
                                end
                                // period 0 wraps to 65535
                                countdown_m[s] = period_m[s] - 16'd1;
                            end
                        end else begin
                            // free slots count down too
                            countdown_m[s] = countdown_m[s] - 16'd1;
                        end
                    end
                end
                dispatches_seen += fired;
                if (fired == 0) begin
                    r.kind       = ptrs_pkg::KIND_IDLE;
                    r.task_index = 3'd0;
                    batch.push_back(r);
                    idle_ticks++;
                end
            end
            ptrs_pkg::CMD_CREATE: begin
                r.task_index = slot;
                if (!occupied_m[slot]) begin
                    occupied_m[slot]  = 1'b1;
                    resumed_m[slot]   = 1'b1;
                    period_m[slot]    = period;
                    countdown_m[slot] = {8'd0, first_delay};
                    r.kind            = ptrs_pkg::KIND_ACCEPT;
                    creates_taken++;
                end else begin
                    r.kind = ptrs_pkg::KIND_REJECT;
                    creates_refused++;
                end
                batch.push_back(r);
            end
            ptrs_pkg::CMD_RESUME:  resumed_m[slot]  = 1'b1;
            ptrs_pkg::CMD_SUSPEND: resumed_m[slot]  = 1'b0;
            // delete keeps period, countdown and resumed mark
            ptrs_pkg::CMD_DELETE:  occupied_m[slot] = 1'b0;
            default: ;   // unknown codes: no effect, no result
        endcase
        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k]) pending_results.push_back(batch[k]);
        end
    endtask

    // Sends one command transaction. Valid is lowered only for a gap, so a
    // back-to-back transaction never sees valid dropped and raised in one step.
    task automatic send_command(input logic [2:0] cmd, input logic [2:0] slot,
                                input logic [15:0] period, input logic [7:0] first_delay);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_slot        <= slot;
        i_period      <= period;
        i_first_delay <= first_delay;
        do @(posedge i_clk); while (o_stall);
        predict_release(cmd, slot, period, first_delay);
        commands_sent++;
    endtask

    // Receiver: per result a random stall, plus one long
    // hold-off on request, counted here.
    initial begin : result_receiver
        int wait_cycles;
        int held;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_pending) begin
                i_stall <= 1'b1;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge i_clk);
                hold_off_pending = 1'b0;
            end
            wait_cycles = no_idle ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_stall === 1'b0));
        end
    end

    // Result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_release_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d task %0d last %0d",
                                          o_kind, o_task_index, o_last));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_kind !== want.kind)
                    report_mismatch($sformatf("result %0d: kind %0d, want %0d",
                                              results_checked, o_kind, want.kind));
                if (o_task_index !== want.task_index)
                    report_mismatch($sformatf("result %0d: task %0d, want %0d",
                                              results_checked, o_task_index,
                                              want.task_index));
                if (o_last !== want.last)
                    report_mismatch($sformatf("result %0d: last %0d, want %0d",
                                              results_checked, o_last, want.last));
            end
        end
    end

    // Field extremes, accept and reject, period 0 wrap on reload
    task automatic test_create_extremes();
        send_command(ptrs_pkg::CMD_CREATE, 3'd0, 16'd0, 8'd0);
        send_command(ptrs_pkg::CMD_CREATE, 3'd7, 16'hFFFF, 8'hFF);
        send_command(ptrs_pkg::CMD_CREATE, 3'd0, 16'h5A5A, 8'hA5);   // slot taken
        send_command(ptrs_pkg::CMD_TICK, 3'd0, 16'd0, 8'd0);   // slot 0 fires, reloads 65535
        send_command(ptrs_pkg::CMD_TICK, 3'd7, 16'hFFFF, 8'hFF);     // nothing fires: idle
    endtask

    // Suspended slots frozen, resume of a never-created slot, delete of a
    // slot with a running countdown, unknown codes
    task automatic test_suspend_resume_delete();
        send_command(ptrs_pkg::CMD_SUSPEND, 3'd0, 16'd0, 8'd0);
        send_command(ptrs_pkg::CMD_TICK, 3'd0, 16'd0, 8'd0);
        send_command(ptrs_pkg::CMD_RESUME, 3'd0, 16'd0, 8'd0);
        send_command(ptrs_pkg::CMD_RESUME, 3'd3, 16'd0, 8'd0);
        send_command(ptrs_pkg::CMD_DELETE, 3'd7, 16'd0, 8'd0);
        send_command(ptrs_pkg::CMD_TICK, 3'd0, 16'd0, 8'd0);   // free slot 7 still counts down
        send_command(3'd5, 3'd1, 16'h1234, 8'h12);
        send_command(3'd6, 3'd2, 16'hFFFF, 8'hFF);
        send_command(3'd7, 3'd7, 16'h0000, 8'h00);
    endtask

    // All slots due in one tick: eight dispatches, the last one flagged
    task automatic test_all_slots_release();
        send_command(ptrs_pkg::CMD_DELETE, 3'd0, 16'd0, 8'd0);
        send_command(ptrs_pkg::CMD_DELETE, 3'd7, 16'd0, 8'd0);
        for (int s = 0; s < SLOT_COUNT; s++)
            send_command(ptrs_pkg::CMD_CREATE, 3'(s), 16'd1, 8'd0);
        send_command(ptrs_pkg::CMD_TICK, 3'd0, 16'd0, 8'd0);
    endtask

    // Receiver holds off for a long stretch while commands keep coming,
    // so the result register fills and the input stalls.
    task automatic test_backpressure();
        no_idle          = 1'b1;
        hold_off_pending = 1'b1;
        for (int s = 0; s < SLOT_COUNT; s += 2)
            send_command(ptrs_pkg::CMD_DELETE, 3'(s), 16'd0, 8'd0);
        for (int s = 0; s < SLOT_COUNT; s += 2)
            send_command(ptrs_pkg::CMD_CREATE, 3'(s), 16'd2, 8'd0);
        repeat (10) send_command(ptrs_pkg::CMD_TICK, 3'd0, 16'd0, 8'd0);
        no_idle = 1'b0;
    endtask

    // Random traffic: mostly ticks and small periods so tasks actually fire,
    // with occasional full-range fields and unknown codes.
    task automatic test_random_traffic();
        int          pick;
        logic [2:0]  cmd;
        logic [2:0]  slot;
        logic [15:0] period;
        logic [7:0]  first_delay;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 120 && n < 170);   // a stretch with no idling
            pick = $urandom_range(0, 99);
            if (pick < 45)      cmd = ptrs_pkg::CMD_TICK;
            else if (pick < 65) cmd = ptrs_pkg::CMD_CREATE;
            else if (pick < 77) cmd = ptrs_pkg::CMD_DELETE;
            else if (pick < 86) cmd = ptrs_pkg::CMD_RESUME;
            else if (pick < 95) cmd = ptrs_pkg::CMD_SUSPEND;
            else                cmd = 3'($urandom_range(5, 7));
            slot = 3'($urandom_range(0, SLOT_COUNT - 1));
            pick = $urandom_range(0, 99);
            if (pick < 80)      period = 16'($urandom_range(0, 4));
            else if (pick < 92) period = 16'($urandom_range(5, 24));
            else                period = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 80) first_delay = 8'($urandom_range(0, 3));
            else           first_delay = 8'($urandom);
            send_command(cmd, slot, period, first_delay);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = ptrs_pkg::CMD_TICK;
        i_slot        = 3'd0;
        i_period      = 16'd0;
        i_first_delay = 8'd0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            occupied_m[s]  = 1'b0;
            resumed_m[s]   = 1'b0;
            period_m[s]    = 16'd0;
            countdown_m[s] = 16'd0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_create_extremes();
        test_suspend_resume_delete();
        test_all_slots_release();
        test_backpressure();
        test_random_traffic();

        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d commands (%0d ticks): %0d dispatches, %0d idle ticks",
                 commands_sent, ticks_sent, dispatches_seen, idle_ticks);
        $display("creates taken %0d, refused %0d; %0d results checked, %0d errors",
                 creates_taken, creates_refused, results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("periodic_task_release_scheduler: match");
        end else begin
            $display("periodic_task_release_scheduler: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ptrs_pkg.sv
rtl/ptrs_ctrl.sv
rtl/ptrs_datapath.sv
rtl/periodic_task_release_scheduler.sv
tb/periodic_task_release_scheduler_tb.sv
